>>> rtl/core/format_spec_parser_defines.svh
// format_spec_parser_defines.svh: assertion macros for the format parser
// expects clk and rst_n in the scope of every use
`ifndef FORMAT_SPEC_PARSER_DEFINES_SVH
`define FORMAT_SPEC_PARSER_DEFINES_SVH

// same-cycle implication, held off while in reset
`define FSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define FSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fsp_pkg.sv
// fsp_pkg: types and constants shared by the format specifier parser
// no dependencies
package fsp_pkg;

  // input item as it arrives on the input channel
  typedef struct packed {
    logic              req_type;
    logic [7:0]        format_byte;
    logic signed [31:0] star_value;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         byte_out;
    logic [9:0]         flag_bits;
    logic [30:0]        field_width;
    logic signed [31:0] field_precision;
  } out_item_t;

  // byte classes found by the front end
  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_STAR,
    CLS_DOT,
    CLS_ZERO,
    CLS_DIGIT,
    CLS_FLAG,
    CLS_LMOD,
    CLS_HMOD,
    CLS_CONV,
    CLS_OTHER
  } cls_t;

  // classified item handed from front to back through the queue
  typedef struct packed {
    logic              req_type;
    cls_t              cls;
    logic [3:0]        digit;
    logic [5:0]        flag_set;
    logic [7:0]        format_byte;
    logic signed [31:0] star_value;
  } q_item_t;

  // result kinds
  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_DESC = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_N     = 8'h6E;

  // flag bit masks
  localparam logic [9:0] F_MINUS = 10'h001;
  localparam logic [9:0] F_ZERO  = 10'h002;
  localparam logic [9:0] F_HASH  = 10'h004;
  localparam logic [9:0] F_APOS  = 10'h008;
  localparam logic [9:0] F_SPACE = 10'h010;
  localparam logic [9:0] F_PLUS  = 10'h020;
  localparam logic [9:0] F_L     = 10'h040;
  localparam logic [9:0] F_LL    = 10'h080;
  localparam logic [9:0] F_H     = 10'h100;
  localparam logic [9:0] F_HH    = 10'h200;

  localparam logic [30:0]        SAT31     = 31'h7FFF_FFFF;
  localparam logic signed [31:0] PREC_NONE = -32'sd1;

endpackage

>>> rtl/core/fsp_front.sv
// fsp_front: input register and byte classification
// depends on fsp_pkg
module fsp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fsp_pkg::in_item_t in_data,
  output logic             push_valid,
  output fsp_pkg::q_item_t push_item,
  input  logic             q_full
);
  import fsp_pkg::*;

  logic     front_valid_r, front_valid_nxt;
  q_item_t  front_item_r, front_item_nxt;
  logic     take;

  // decode one format byte into its class and flag mask
  always_comb begin
    front_item_nxt             = '0;
    front_item_nxt.req_type    = in_data.req_type;
    front_item_nxt.format_byte = in_data.format_byte;
    front_item_nxt.star_value  = in_data.star_value;
    front_item_nxt.digit       = 4'(in_data.format_byte - CH_0);
    front_item_nxt.flag_set    = '0;
    unique case (in_data.format_byte) inside
      CH_NUL:       front_item_nxt.cls = CLS_NUL;
      CH_STAR:      front_item_nxt.cls = CLS_STAR;
      CH_DOT:       front_item_nxt.cls = CLS_DOT;
      CH_0:         front_item_nxt.cls = CLS_ZERO;
      [CH_1:CH_9]:  front_item_nxt.cls = CLS_DIGIT;
      CH_MINUS: begin
        front_item_nxt.cls      = CLS_FLAG;
        front_item_nxt.flag_set = F_MINUS[5:0];
      end
      CH_HASH: begin
        front_item_nxt.cls      = CLS_FLAG;
        front_item_nxt.flag_set = F_HASH[5:0];
      end
      CH_APOS: begin
        front_item_nxt.cls      = CLS_FLAG;
        front_item_nxt.flag_set = F_APOS[5:0];
      end
      CH_SPACE: begin
        front_item_nxt.cls      = CLS_FLAG;
        front_item_nxt.flag_set = F_SPACE[5:0];
      end
      CH_PLUS: begin
        front_item_nxt.cls      = CLS_FLAG;
        front_item_nxt.flag_set = F_PLUS[5:0];
      end
      CH_L:         front_item_nxt.cls = CLS_LMOD;
      CH_H:         front_item_nxt.cls = CLS_HMOD;
      CH_PCT, CH_C, CH_D, CH_I, CH_U, CH_S, CH_X, CH_XU, CH_O, CH_P, CH_N:
                    front_item_nxt.cls = CLS_CONV;
      default:      front_item_nxt.cls = CLS_OTHER;
    endcase
  end

  // one-entry stage, drains into the queue whenever it has room
  assign in_stall   = front_valid_r && q_full;
  assign take       = in_valid && !in_stall;
  assign push_valid = front_valid_r && !q_full;
  assign push_item  = front_item_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (take) begin
      front_valid_nxt = 1'b1;
    end else if (push_valid) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      front_item_r <= front_item_nxt;
    end
  end

endmodule

>>> rtl/core/fsp_queue.sv
// fsp_queue: two-entry queue between the classifier and the parser
// depends on fsp_pkg
module fsp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  fsp_pkg::q_item_t push_item,
  output logic             full,
  output logic             pop_valid,
  output fsp_pkg::q_item_t pop_item,
  input  logic             pop
);
  import fsp_pkg::*;

  q_item_t     slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/core/fsp_back.sv
// fsp_back: specifier state machine, digit accumulator and output register
// depends on fsp_pkg and format_spec_parser_defines.svh
`include "format_spec_parser_defines.svh"

module fsp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  fsp_pkg::q_item_t  q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fsp_pkg::out_item_t out_data
);
  import fsp_pkg::*;

  typedef enum logic [2:0] {
    M_LIT,
    M_SPEC,
    M_WDIG,
    M_PSTART,
    M_PDIG,
    M_WSTAR,
    M_PSTAR
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [9:0]         flags_r, flags_nxt;
  logic [30:0]        width_r, width_nxt;
  logic signed [31:0] prec_r, prec_nxt;
  logic [30:0]        acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic        emit;
  out_item_t   res;
  logic        do_spec;
  logic        is_dig;
  logic [34:0] acc_sum;
  logic [30:0] acc_sat;
  logic        neg;
  logic [31:0] neg_val;
  logic        byte_in_wait;
  logic        desc_out;

  // a new item is taken whenever the output register is free or drains
  assign pop = q_valid && (!out_valid_r || !out_stall);

  assign is_dig = (q_item.cls == CLS_ZERO) || (q_item.cls == CLS_DIGIT);

  // acc * 10 + digit, saturating at 2^31-1
  assign acc_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 35'(q_item.digit);
  assign acc_sat = (acc_sum > 35'(SAT31)) ? SAT31 : acc_sum[30:0];

  assign neg     = q_item.star_value[31];
  assign neg_val = 32'(32'sd0 - q_item.star_value);

  // parse step for the item at the queue head
  always_comb begin
    mode_nxt  = mode_r;
    flags_nxt = flags_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    acc_nxt   = acc_r;
    emit      = 1'b0;
    res       = '0;
    do_spec   = 1'b0;

    if (q_item.req_type) begin
      // star value answers a pending request, otherwise ignored
      if (mode_r == M_WSTAR) begin
        if (neg) begin
          flags_nxt = flags_r | F_MINUS;
          width_nxt = (q_item.star_value == 32'sh8000_0000) ? SAT31 : neg_val[30:0];
        end else begin
          width_nxt = q_item.star_value[30:0];
        end
        mode_nxt = M_SPEC;
      end else if (mode_r == M_PSTAR) begin
        prec_nxt = neg ? PREC_NONE : q_item.star_value;
        mode_nxt = M_SPEC;
      end
    end else begin
      unique case (mode_r)
        M_SPEC: do_spec = 1'b1;
        M_WDIG: begin
          if (is_dig) begin
            acc_nxt = acc_sat;
          end else begin
            width_nxt = acc_r;
            do_spec   = 1'b1;
          end
        end
        M_PSTART: begin
          if (q_item.cls == CLS_STAR) begin
            mode_nxt     = M_PSTAR;
            emit         = 1'b1;
            res.kind     = KIND_REQ;
            res.byte_out = CH_STAR;
          end else if (is_dig) begin
            acc_nxt  = 31'(q_item.digit);
            mode_nxt = M_PDIG;
          end else begin
            prec_nxt = '0;
            do_spec  = 1'b1;
          end
        end
        M_PDIG: begin
          if (is_dig) begin
            acc_nxt = acc_sat;
          end else begin
            prec_nxt = {1'b0, acc_r};
            do_spec  = 1'b1;
          end
        end
        M_WSTAR, M_PSTAR: begin
          // format bytes are dropped while a star value is awaited
        end
        M_LIT: begin
          if (q_item.cls == CLS_NUL) begin
            emit     = 1'b1;
            res.kind = KIND_END;
          end else if (q_item.format_byte == CH_PCT) begin
            flags_nxt = '0;
            width_nxt = '0;
            prec_nxt  = PREC_NONE;
            mode_nxt  = M_SPEC;
          end else begin
            emit         = 1'b1;
            res.kind     = KIND_LIT;
            res.byte_out = q_item.format_byte;
          end
        end
        default: mode_nxt = M_LIT;
      endcase

      // byte handled as part of a specifier
      if (do_spec) begin
        mode_nxt = M_SPEC;
        unique case (q_item.cls)
          CLS_NUL: begin
            mode_nxt = M_LIT;
            emit     = 1'b1;
            res.kind = KIND_END;
          end
          CLS_STAR: begin
            mode_nxt     = M_WSTAR;
            emit         = 1'b1;
            res.kind     = KIND_REQ;
            res.byte_out = CH_STAR;
          end
          CLS_DIGIT: begin
            acc_nxt  = 31'(q_item.digit);
            mode_nxt = M_WDIG;
          end
          CLS_DOT:  mode_nxt = M_PSTART;
          CLS_ZERO: flags_nxt = flags_r | F_ZERO;
          CLS_FLAG: flags_nxt = flags_r | {4'b0000, q_item.flag_set};
          CLS_LMOD: flags_nxt = flags_r | ((flags_r & F_L) != '0 ? F_LL : F_L);
          CLS_HMOD: flags_nxt = flags_r | ((flags_r & F_H) != '0 ? F_HH : F_H);
          CLS_CONV: begin
            mode_nxt            = M_LIT;
            emit                = 1'b1;
            res.kind            = KIND_DESC;
            res.byte_out        = q_item.format_byte;
            res.flag_bits       = flags_r;
            res.field_width     = width_nxt;
            res.field_precision = prec_nxt;
          end
          CLS_OTHER: begin
            mode_nxt     = M_LIT;
            emit         = 1'b1;
            res.kind     = KIND_LIT;
            res.byte_out = q_item.format_byte;
          end
          default: mode_nxt = M_LIT;
        endcase
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (pop && emit) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // parse state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_LIT;
      flags_r     <= '0;
      width_r     <= '0;
      prec_r      <= PREC_NONE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
    end else begin
      if (pop) begin
        mode_r  <= mode_nxt;
        flags_r <= flags_nxt;
        width_r <= width_nxt;
        prec_r  <= prec_nxt;
        acc_r   <= acc_nxt;
      end
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // checks
  assign byte_in_wait = pop && !q_item.req_type && ((mode_r == M_WSTAR) || (mode_r == M_PSTAR));
  assign desc_out     = pop && emit && (res.kind == KIND_DESC);

  `FSP_ASSERT_NXT(a_star_wait_silent, byte_in_wait, !out_valid_r, "star wait produced an item")
  `FSP_ASSERT_NXT(a_desc_closes_spec, desc_out, mode_r == M_LIT, "descriptor left spec open")
  `FSP_ASSERT_IMP(a_prec_floor, prec_r[31], prec_r == PREC_NONE, "precision below minus one")

endmodule

>>> rtl/core/format_spec_parser.sv
// format_spec_parser: top level of the printf format specifier parser
// depends on fsp_pkg, fsp_front, fsp_queue, fsp_back
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | fsp_pkg::in_item_t
//   out_    | output    | out_valid / out_stall | fsp_pkg::out_item_t
//
// one item per cycle sustained while the output does not stall; an item passes
// the front register, the two-entry queue and the output register on its way to a result
// the back end parses one item per cycle unless stalled; its path is one x10 add and compare
// reset is synchronous, active low, and puts the parser in literal mode
// a stalled output holds the back end; the queue then fills and in_stall rises
module format_spec_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fsp_pkg::out_item_t out_data
);
  import fsp_pkg::*;

  logic    push_valid;
  q_item_t push_item;
  logic    q_full;
  logic    q_valid;
  q_item_t q_item;
  logic    pop;

  // classifier
  fsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  // decoupling queue
  fsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (pop)
  );

  // parser and output register
  fsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/format_spec_parser_tb.sv
// format_spec_parser_tb: self-checking testbench for the format specifier parser
// depends on fsp_pkg and format_spec_parser; a local parse model predicts each result
`timescale 1ns / 100ps

module format_spec_parser_tb;
  import fsp_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ITEM_TARGET    = 1050;

  // parser modes of the local model
  typedef enum logic [2:0] {
    PM_LIT, PM_SPEC, PM_WDIG, PM_PSTART, PM_PDIG, PM_WSTAR, PM_PSTAR
  } scan_mode_t;

  bit        clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // model state
  scan_mode_t  pm;
  logic [9:0]  spec_fl;
  logic [30:0] fw_reg;
  logic [31:0] fp_reg;
  logic [30:0] digits_acc;

  out_item_t pending_tokens[$];
  int        err_count;
  int        items_sent;
  int        items_parsed;
  int        results_checked;
  int        idle_cycles;
  bit        tx_idle_on;
  bit        rx_idle_on;
  bit        long_hold_req;

  format_spec_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit is_dec(input logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic bit is_conv_char(input logic [7:0] b);
    return b == CH_PCT || b == CH_C || b == CH_D || b == CH_I || b == CH_U ||
           b == CH_S || b == CH_X || b == CH_XU || b == CH_O || b == CH_P || b == CH_N;
  endfunction

  // decimal accumulate, saturating at 2^31-1
  function automatic logic [30:0] add_digit(input logic [30:0] acc, input logic [3:0] d);
    if ({1'b0, acc} > (32'(SAT31) - 32'(d)) / 32'd10) return SAT31;
    return acc * 31'd10 + 31'(d);
  endfunction

  // one byte seen inside a specifier
  function automatic bit spec_step(input logic [7:0] b, output out_item_t res);
    res = '0;
    if (b == CH_NUL) begin
      pm = PM_LIT;
      res.kind = KIND_END;
      return 1'b1;
    end
    if (b == CH_STAR) begin
      pm = PM_WSTAR;
      res.kind = KIND_REQ;
      res.byte_out = CH_STAR;
      return 1'b1;
    end
    if (b >= CH_1 && b <= CH_9) begin
      digits_acc = 31'(b - CH_0);
      pm = PM_WDIG;
      return 1'b0;
    end
    if (b == CH_DOT) begin
      pm = PM_PSTART;
      return 1'b0;
    end
    case (b)
      CH_MINUS: begin spec_fl |= F_MINUS; return 1'b0; end
      CH_0:     begin spec_fl |= F_ZERO;  return 1'b0; end
      CH_HASH:  begin spec_fl |= F_HASH;  return 1'b0; end
      CH_APOS:  begin spec_fl |= F_APOS;  return 1'b0; end
      CH_SPACE: begin spec_fl |= F_SPACE; return 1'b0; end
      CH_PLUS:  begin spec_fl |= F_PLUS;  return 1'b0; end
      CH_L: begin
        spec_fl |= ((spec_fl & F_L) != 0) ? F_LL : F_L;
        return 1'b0;
      end
      CH_H: begin
        spec_fl |= ((spec_fl & F_H) != 0) ? F_HH : F_H;
        return 1'b0;
      end
      default: ;
    endcase
    pm = PM_LIT;
    res.byte_out = b;
    if (is_conv_char(b)) begin
      res.kind = KIND_DESC;
      res.flag_bits = spec_fl;
      res.field_width = fw_reg;
      res.field_precision = fp_reg;
    end else begin
      res.kind = KIND_LIT;
    end
    return 1'b1;
  endfunction

  // advance the model by one item; returns 1 when a result is due
  function automatic bit parse_format_item(input in_item_t it, output out_item_t res);
    logic [31:0] sv;
    logic [7:0]  b;
    sv = it.star_value;
    b = it.format_byte;
    res = '0;
    if (it.req_type) begin
      if (pm == PM_WSTAR) begin
        if (sv[31]) begin
          spec_fl |= F_MINUS;
          fw_reg = (sv == 32'h8000_0000) ? SAT31 : 31'(32'd0 - sv);
        end else begin
          fw_reg = sv[30:0];
        end
        pm = PM_SPEC;
      end else if (pm == PM_PSTAR) begin
        fp_reg = sv[31] ? PREC_NONE : sv;
        pm = PM_SPEC;
      end
      return 1'b0;
    end
    case (pm)
      PM_SPEC: return spec_step(b, res);
      PM_WDIG: begin
        if (is_dec(b)) begin
          digits_acc = add_digit(digits_acc, 4'(b - CH_0));
          return 1'b0;
        end
        fw_reg = digits_acc;
        pm = PM_SPEC;
        return spec_step(b, res);
      end
      PM_PSTART: begin
        if (b == CH_STAR) begin
          pm = PM_PSTAR;
          res.kind = KIND_REQ;
          res.byte_out = CH_STAR;
          return 1'b1;
        end
        if (is_dec(b)) begin
          digits_acc = 31'(b - CH_0);
          pm = PM_PDIG;
          return 1'b0;
        end
        fp_reg = '0;
        pm = PM_SPEC;
        return spec_step(b, res);
      end
      PM_PDIG: begin
        if (is_dec(b)) begin
          digits_acc = add_digit(digits_acc, 4'(b - CH_0));
          return 1'b0;
        end
        fp_reg = {1'b0, digits_acc};
        pm = PM_SPEC;
        return spec_step(b, res);
      end
      PM_WSTAR, PM_PSTAR: return 1'b0;
      default: begin
        pm = PM_LIT;
        if (b == CH_NUL) begin
          res.kind = KIND_END;
          return 1'b1;
        end
        if (b == CH_PCT) begin
          spec_fl = '0;
          fw_reg = '0;
          fp_reg = PREC_NONE;
          pm = PM_SPEC;
          return 1'b0;
        end
        res.kind = KIND_LIT;
        res.byte_out = b;
        return 1'b1;
      end
    endcase
  endfunction

  // offer one item, hold it until accepted, then predict its result
  task automatic send_item(input in_item_t it);
    int        gap;
    bit        parked;
    bit        due;
    out_item_t res;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parked = (pm == PM_WSTAR || pm == PM_PSTAR);
    if (it.req_type != parked) items_parsed++;
    items_sent++;
    due = parse_format_item(it, res);
    if (due) pending_tokens.push_back(res);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.req_type = 1'b0;
    it.format_byte = b;
    it.star_value = $urandom();
    send_item(it);
  endtask

  task automatic send_star(input logic [31:0] v);
    in_item_t it;
    it.req_type = 1'b1;
    it.format_byte = 8'($urandom_range(0, 255));
    it.star_value = v;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_digits(input int count, input bit lead_nonzero);
    logic [7:0] d;
    for (int i = 0; i < count; i++) begin
      d = 8'((i == 0 && lead_nonzero) ? $urandom_range(1, 9) : $urandom_range(0, 9));
      send_byte(CH_0 + d);
    end
  endtask

  function automatic logic [31:0] rand_star();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 20);
      3: return 32'd0 - $urandom_range(1, 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] pick_flag_char();
    case ($urandom_range(0, 5))
      0: return CH_MINUS;
      1: return CH_0;
      2: return CH_HASH;
      3: return CH_APOS;
      4: return CH_SPACE;
      default: return CH_PLUS;
    endcase
  endfunction

  function automatic logic [7:0] pick_conv_char();
    case ($urandom_range(0, 10))
      0: return CH_PCT;
      1: return CH_C;
      2: return CH_D;
      3: return CH_I;
      4: return CH_U;
      5: return CH_S;
      6: return CH_X;
      7: return CH_XU;
      8: return CH_O;
      9: return CH_P;
      default: return CH_N;
    endcase
  endfunction

  // star request, sometimes with a stray format byte before the answer
  task automatic send_star_field();
    send_byte(CH_STAR);
    if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
    send_star(rand_star());
  endtask

  // one specifier with random content; a few end badly
  task automatic send_random_spec();
    int r;
    send_byte(CH_PCT);
    repeat ($urandom_range(0, 4)) send_byte(pick_flag_char());
    case ($urandom_range(0, 5))
      2, 3: send_digits($urandom_range(1, 3), 1'b1);
      4:    send_digits($urandom_range(9, 12), 1'b1);
      5:    send_star_field();
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) begin
      send_byte(CH_DOT);
      case ($urandom_range(0, 4))
        1, 2: send_digits($urandom_range(1, 3), 1'b0);
        3:    send_digits($urandom_range(9, 12), 1'b0);
        4:    send_star_field();
        default: ;
      endcase
    end
    repeat ($urandom_range(0, 2)) send_byte(($urandom_range(0, 1) == 1) ? CH_L : CH_H);
    r = $urandom_range(0, 19);
    if (r < 16) send_byte(pick_conv_char());
    else if (r < 19) send_byte(8'($urandom_range(0, 255)));
    else send_byte(CH_NUL);
  endtask

  // mostly specifiers, with literals, stray star values and raw noise
  task automatic send_random_items(input int goal);
    int r;
    logic [7:0] b;
    while (items_parsed < goal) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        send_random_spec();
      end else if (r < 8) begin
        b = 8'($urandom_range(1, 255));
        send_byte((b == CH_PCT) ? CH_PCT + 8'd1 : b);
      end else if (r == 8) begin
        send_star(rand_star());
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // all flags, both doubled length modifiers
  task automatic test_flags_and_lengths();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_text("%-0#' +llhhd");
  endtask

  // star width at the negative extreme, format byte while waiting, negative star precision
  task automatic test_star_arguments();
    send_text("%*");
    send_byte("z");
    send_star(32'h8000_0000);
    send_text(".*");
    send_star(32'hFFFF_FFFF);
    send_byte(CH_X);
  endtask

  // bare dot then unknown conversion, nul inside a specifier, stray star, byte extremes
  task automatic test_odd_bytes();
    send_text("%.q%5");
    send_byte(CH_NUL);
    send_star(32'h7FFF_FFFF);
    send_byte(8'hFF);
    send_byte(CH_NUL);
  endtask

  // receiver holds off for a long stretch while the sender keeps going
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (6) send_text("%-12.4lx|");
  endtask

  task automatic test_random_streaming();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random_items(items_parsed + 300);
  endtask

  task automatic test_random_with_gaps();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random_items(ITEM_TARGET);
  endtask

  // result side stall pattern
  initial begin : result_stall_gen
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        if (rx_idle_on) hold_left = pick_gap();
      end
    end
  end

  task automatic note_mismatch(input string what, input out_item_t exp_item,
                               input out_item_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%s: exp kind=%0d byte=%02h flags=%03h w=%0d p=%0d",
               what, exp_item.kind, exp_item.byte_out, exp_item.flag_bits,
               exp_item.field_width, $signed(exp_item.field_precision));
      $display("  got kind=%0d byte=%02h flags=%03h w=%0d p=%0d",
               got.kind, got.byte_out, got.flag_bits, got.field_width,
               $signed(got.field_precision));
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_tokens.size() == 0) begin
        note_mismatch("unexpected result", '0, out_data);
      end else begin
        if (out_data.kind !== pending_tokens[0].kind ||
            out_data.byte_out !== pending_tokens[0].byte_out ||
            out_data.flag_bits !== pending_tokens[0].flag_bits ||
            out_data.field_width !== pending_tokens[0].field_width ||
            out_data.field_precision !== pending_tokens[0].field_precision)
          note_mismatch("mismatch", pending_tokens[0], out_data);
        void'(pending_tokens.pop_front());
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_tokens.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    idle_cycles = 0;
    pm = PM_LIT;
    spec_fl = '0;
    fw_reg = '0;
    fp_reg = PREC_NONE;
    digits_acc = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_flags_and_lengths();
    test_star_arguments();
    test_odd_bytes();
    test_backpressure();
    test_random_streaming();
    test_random_with_gaps();

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items (%0d parsed) and %0d results",
             items_sent, items_parsed, results_checked);
    $display("random gaps, a %0d-cycle output hold, %0d mismatches", LONG_HOLD, err_count);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
